>>> rtl/dsa_signature_sign_macros.svh
// assertion helpers for the signing block
`ifndef DSA_SIGNATURE_SIGN_MACROS_SVH
`define DSA_SIGNATURE_SIGN_MACROS_SVH

// same-cycle implication
`define DSS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DSS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/dss_pkg.sv
`timescale 1ns / 1ps
package dss_pkg;

   localparam logic [1:0] CSR_MODULUS_P      = 2'd0;
   localparam logic [1:0] CSR_SUBGROUP_Q     = 2'd1;
   localparam logic [1:0] CSR_GENERATOR_SEED = 2'd2;
   localparam logic [1:0] CSR_PRIVATE_KEY    = 2'd3;

   localparam logic [15:0] RST_MODULUS_P      = 16'd23;
   localparam logic [15:0] RST_SUBGROUP_Q     = 16'd11;
   localparam logic [15:0] RST_GENERATOR_SEED = 16'd2;
   localparam logic [15:0] RST_PRIVATE_KEY    = 16'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NONINV = 2'd1;
   localparam logic [1:0] ST_R_ZERO = 2'd2;
   localparam logic [1:0] ST_S_ZERO = 2'd3;

   typedef struct packed {
      logic [15:0] modulus_p;
      logic [15:0] subgroup_q;
      logic [15:0] generator_seed;
      logic [15:0] private_key;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_E_DIV,
      OP_E_ZERO,
      OP_POW_INIT,
      OP_POW_ZERO,
      OP_POW_DONE,
      OP_BASE_RED,
      OP_MUL_ACC,
      OP_MUL_SQ,
      OP_R_DIV,
      OP_R_ZERO,
      OP_K_RED,
      OP_EU_DIV,
      OP_EU_MUL,
      OP_EU_STEP,
      OP_H_RED,
      OP_XR_MUL,
      OP_T_ADD,
      OP_S_MUL,
      OP_S_ZERO,
      OP_OUT
   } op_type;

   typedef enum logic [1:0] {
      POW_G,
      POW_Y,
      POW_GK
   } pow_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_EXP,
      S_POW_START,
      S_POW_RED,
      S_POW_LOOP,
      S_POW_SQ,
      S_POW_END,
      S_R,
      S_INV_INIT,
      S_EU_LOOP,
      S_EU_MUL,
      S_EU_STEP,
      S_H_RED,
      S_XR,
      S_T_ADD,
      S_S_MUL,
      S_FAIL,
      S_OUT,
      S_WAIT
   } state_type;

   typedef struct packed {
      op_type  op;
      pow_type pow_sel;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic out_free;
      logic p_zero;
      logic q_zero;
      logic q_lt2;
      logic ex_zero;
      logic ex_lsb;
      logic r1_zero;
      logic r0_one;
   } sts_type;

endpackage

>>> rtl/dss_ifs.sv
`timescale 1ns / 1ps
interface dss_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] message;
   logic [15:0] hash_key;
   logic [15:0] nonce;
   modport source (output valid, output message, output hash_key, output nonce, input ready);
   modport sink (input valid, input message, input hash_key, input nonce, output ready);
endinterface

interface dss_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] sig_r;
   logic [15:0] sig_s;
   logic [15:0] public_key;
   logic [1:0]  status;
   modport source (output valid, output sig_r, output sig_s, output public_key,
                   output status, input ready);
   modport sink (input valid, input sig_r, input sig_s, input public_key,
                 input status, output ready);
endinterface

>>> rtl/dss_datapath.sv
`timescale 1ns / 1ps
module dss_datapath import dss_pkg::*; #(
   parameter int MOD_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  cfg_type             cfg,
   input  logic [15:0]         message,
   input  logic [15:0]         hash_key,
   input  logic [15:0]         nonce,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [MOD_BITS-1:0] sig_r,
   output logic [MOD_BITS-1:0] sig_s,
   output logic [MOD_BITS-1:0] public_key,
   output logic [1:0]          status
);

   localparam int W  = MOD_BITS;
   localparam int CW = $clog2(MOD_BITS);

   // a, b < m
   function automatic logic [W-1:0] add_m(input logic [W-1:0] a, input logic [W-1:0] b,
                                          input logic [W-1:0] m);
      logic [W-1:0] gap;
      gap = m - b;
      return (a >= gap) ? (a - gap) : (a + b);
   endfunction

   function automatic logic [W-1:0] sub_m(input logic [W-1:0] a, input logic [W-1:0] b,
                                          input logic [W-1:0] m);
      return (a >= b) ? (a - b) : (a + (m - b));
   endfunction

   logic [W-1:0] p, q, h, x;
   assign p = W'(cfg.modulus_p);
   assign q = W'(cfg.subgroup_q);
   assign h = W'(cfg.generator_seed);
   assign x = W'(cfg.private_key);

   logic [W-1:0] k_ff, hd_ff, e_ff, base_ff, ex_ff, acc_ff, g_ff, y_ff, gk_ff, r_ff;
   logic [W-1:0] r0_ff, r1_ff, t0_ff, t1_ff, quo_ff, rem_ff, prod_ff, hq_ff, xr_ff;
   logic [W-1:0] t_ff, s_ff;
   logic         fail_ff;

   logic [W-1:0] out_r_ff, out_s_ff, out_y_ff;
   logic [1:0]   out_st_ff;
   logic         rsp_valid_ff;

   logic          busy_ff;
   logic [CW-1:0] cnt_ff;
   op_type        uop_ff;
   logic          last;
   logic          unit_start;

   // shared add-and-double multiplier
   logic [W-1:0] mul_acc_ff, mul_a_ff, mul_b_ff, mul_m_ff;
   logic [W-1:0] mul_sum, mul_acc_in, mul_a_in, mul_b_in;

   // shared restoring divider
   logic [W-1:0] div_n_ff, div_r_ff, div_d_ff;
   logic [W:0]   div_sh, div_sub;
   logic         div_ge;
   logic [W-1:0] div_n_in, div_r_in;

   assign mul_sum    = add_m(mul_acc_ff, mul_a_ff, mul_m_ff);
   assign mul_acc_in = mul_b_ff[0] ? mul_sum : mul_acc_ff;
   assign mul_a_in   = add_m(mul_a_ff, mul_a_ff, mul_m_ff);
   assign mul_b_in   = mul_b_ff >> 1;

   assign div_sh   = {div_r_ff, div_n_ff[W-1]};
   assign div_sub  = div_sh - {1'b0, div_d_ff};
   assign div_ge   = (div_sh >= {1'b0, div_d_ff});
   assign div_r_in = div_ge ? div_sub[W-1:0] : div_sh[W-1:0];
   assign div_n_in = {div_n_ff[W-2:0], div_ge};

   assign last = busy_ff && (cnt_ff == CW'(W - 1));

   always_comb begin
      case (cmd.op)
         OP_E_DIV, OP_BASE_RED, OP_R_DIV, OP_K_RED, OP_EU_DIV, OP_H_RED,
         OP_MUL_ACC, OP_MUL_SQ, OP_EU_MUL, OP_XR_MUL, OP_S_MUL: unit_start = 1'b1;
         default: unit_start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (last) begin
               busy_ff <= 1'b0;
            end
         end else if (unit_start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end
         if (cmd.op == OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mul_acc_ff <= mul_acc_in;
         mul_a_ff   <= mul_a_in;
         mul_b_ff   <= mul_b_in;
         div_n_ff   <= div_n_in;
         div_r_ff   <= div_r_in;
      end
      if (last) begin
         case (uop_ff)
            OP_E_DIV:    e_ff    <= div_n_in;
            OP_BASE_RED: base_ff <= div_r_in;
            OP_R_DIV:    r_ff    <= div_r_in;
            OP_K_RED:    r1_ff   <= div_r_in;
            OP_EU_DIV: begin
               quo_ff <= div_n_in;
               rem_ff <= div_r_in;
            end
            OP_H_RED:    hq_ff   <= div_r_in;
            OP_MUL_ACC:  acc_ff  <= mul_acc_in;
            OP_MUL_SQ: begin
               base_ff <= mul_acc_in;
               ex_ff   <= ex_ff >> 1;
            end
            OP_EU_MUL:   prod_ff <= mul_acc_in;
            OP_XR_MUL:   xr_ff   <= mul_acc_in;
            OP_S_MUL:    s_ff    <= mul_acc_in;
            default: ;
         endcase
      end
      if (unit_start) begin
         uop_ff     <= cmd.op;
         mul_acc_ff <= '0;
         div_r_ff   <= '0;
      end
      case (cmd.op)
         OP_LOAD: begin
            k_ff    <= W'(nonce);
            hd_ff   <= W'(message ^ hash_key);
            fail_ff <= 1'b0;
         end
         OP_E_DIV: begin
            div_n_ff <= p - W'(1);
            div_d_ff <= q;
         end
         OP_E_ZERO: e_ff <= '0;
         OP_POW_INIT: begin
            acc_ff <= W'(p != W'(1));
            case (cmd.pow_sel)
               POW_G: begin
                  base_ff <= h;
                  ex_ff   <= e_ff;
               end
               POW_Y: begin
                  base_ff <= g_ff;
                  ex_ff   <= x;
               end
               default: begin
                  base_ff <= g_ff;
                  ex_ff   <= k_ff;
               end
            endcase
         end
         OP_POW_ZERO, OP_POW_DONE: begin
            case (cmd.pow_sel)
               POW_G:   g_ff  <= (cmd.op == OP_POW_DONE) ? acc_ff : '0;
               POW_Y:   y_ff  <= (cmd.op == OP_POW_DONE) ? acc_ff : '0;
               default: gk_ff <= (cmd.op == OP_POW_DONE) ? acc_ff : '0;
            endcase
         end
         OP_BASE_RED: begin
            div_n_ff <= base_ff;
            div_d_ff <= p;
         end
         OP_MUL_ACC: begin
            mul_a_ff <= acc_ff;
            mul_b_ff <= base_ff;
            mul_m_ff <= p;
         end
         OP_MUL_SQ: begin
            mul_a_ff <= base_ff;
            mul_b_ff <= base_ff;
            mul_m_ff <= p;
         end
         OP_R_DIV: begin
            div_n_ff <= gk_ff;
            div_d_ff <= q;
         end
         OP_R_ZERO: r_ff <= '0;
         OP_K_RED: begin
            div_n_ff <= k_ff;
            div_d_ff <= q;
            r0_ff    <= q;
            t0_ff    <= '0;
            t1_ff    <= W'(1);
         end
         OP_EU_DIV: begin
            div_n_ff <= r0_ff;
            div_d_ff <= r1_ff;
         end
         OP_EU_MUL: begin
            mul_a_ff <= t1_ff;
            mul_b_ff <= quo_ff;
            mul_m_ff <= q;
         end
         OP_EU_STEP: begin
            r0_ff <= r1_ff;
            r1_ff <= rem_ff;
            t0_ff <= t1_ff;
            t1_ff <= sub_m(t0_ff, prod_ff, q);
         end
         OP_H_RED: begin
            div_n_ff <= hd_ff;
            div_d_ff <= q;
         end
         OP_XR_MUL: begin
            mul_a_ff <= r_ff;
            mul_b_ff <= x;
            mul_m_ff <= q;
         end
         OP_T_ADD: t_ff <= add_m(hq_ff, xr_ff, q);
         OP_S_MUL: begin
            mul_a_ff <= t0_ff;
            mul_b_ff <= t_ff;
            mul_m_ff <= q;
         end
         OP_S_ZERO: begin
            s_ff    <= '0;
            fail_ff <= 1'b1;
         end
         OP_OUT: begin
            out_r_ff <= r_ff;
            out_s_ff <= s_ff;
            out_y_ff <= y_ff;
            if (fail_ff) begin
               out_st_ff <= ST_NONINV;
            end else if (r_ff == '0) begin
               out_st_ff <= ST_R_ZERO;
            end else if (s_ff == '0) begin
               out_st_ff <= ST_S_ZERO;
            end else begin
               out_st_ff <= ST_OK;
            end
         end
         default: ;
      endcase
   end

   assign sts.busy     = busy_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign sts.p_zero   = (p == '0);
   assign sts.q_zero   = (q == '0);
   assign sts.q_lt2    = (q < W'(2));
   assign sts.ex_zero  = (ex_ff == '0);
   assign sts.ex_lsb   = ex_ff[0];
   assign sts.r1_zero  = (r1_ff == '0);
   assign sts.r0_one   = (r0_ff == W'(1));

   assign rsp_valid  = rsp_valid_ff;
   assign sig_r      = out_r_ff;
   assign sig_s      = out_s_ff;
   assign public_key = out_y_ff;
   assign status     = out_st_ff;

endmodule

>>> rtl/dss_ctrl.sv
`timescale 1ns / 1ps
module dss_ctrl import dss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   pow_type   pow_sel_ff, pow_sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ret_ff     <= S_IDLE;
         pow_sel_ff <= POW_G;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         pow_sel_ff <= pow_sel_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      pow_sel_in = pow_sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in   = S_EXP;
               pow_sel_in = POW_G;
            end
         end
         S_EXP: begin
            if (sts.p_zero || sts.q_zero) begin
               state_in = S_POW_START;
            end else begin
               state_in = S_WAIT;
               ret_in   = S_POW_START;
            end
         end
         S_POW_START: state_in = sts.p_zero ? S_POW_END : S_POW_RED;
         S_POW_RED: begin
            state_in = S_WAIT;
            ret_in   = S_POW_LOOP;
         end
         S_POW_LOOP: begin
            if (sts.ex_zero) begin
               state_in = S_POW_END;
            end else if (sts.ex_lsb) begin
               state_in = S_WAIT;
               ret_in   = S_POW_SQ;
            end else begin
               state_in = S_POW_SQ;
            end
         end
         S_POW_SQ: begin
            state_in = S_WAIT;
            ret_in   = S_POW_LOOP;
         end
         S_POW_END: begin
            case (pow_sel_ff)
               POW_G: begin
                  pow_sel_in = POW_Y;
                  state_in   = S_POW_START;
               end
               POW_Y: begin
                  pow_sel_in = POW_GK;
                  state_in   = S_POW_START;
               end
               default: state_in = S_R;
            endcase
         end
         S_R: begin
            if (sts.q_zero) begin
               state_in = S_INV_INIT;
            end else begin
               state_in = S_WAIT;
               ret_in   = S_INV_INIT;
            end
         end
         S_INV_INIT: begin
            if (sts.q_lt2) begin
               state_in = S_FAIL;
            end else begin
               state_in = S_WAIT;
               ret_in   = S_EU_LOOP;
            end
         end
         S_EU_LOOP: begin
            if (sts.r1_zero) begin
               state_in = sts.r0_one ? S_H_RED : S_FAIL;
            end else begin
               state_in = S_WAIT;
               ret_in   = S_EU_MUL;
            end
         end
         S_EU_MUL: begin
            state_in = S_WAIT;
            ret_in   = S_EU_STEP;
         end
         S_EU_STEP: state_in = S_EU_LOOP;
         S_H_RED: begin
            state_in = S_WAIT;
            ret_in   = S_XR;
         end
         S_XR: begin
            state_in = S_WAIT;
            ret_in   = S_T_ADD;
         end
         S_T_ADD: state_in = S_S_MUL;
         S_S_MUL: begin
            state_in = S_WAIT;
            ret_in   = S_OUT;
         end
         S_FAIL: state_in = S_OUT;
         S_OUT: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         S_WAIT: begin
            if (!sts.busy) begin
               state_in = ret_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op      = OP_NONE;
      cmd.pow_sel = pow_sel_ff;
      req_ready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_LOAD;
            end
         end
         S_EXP:       cmd.op = (sts.p_zero || sts.q_zero) ? OP_E_ZERO : OP_E_DIV;
         S_POW_START: cmd.op = sts.p_zero ? OP_POW_ZERO : OP_POW_INIT;
         S_POW_RED:   cmd.op = OP_BASE_RED;
         S_POW_LOOP: begin
            if (sts.ex_zero) begin
               cmd.op = OP_POW_DONE;
            end else if (sts.ex_lsb) begin
               cmd.op = OP_MUL_ACC;
            end
         end
         S_POW_SQ:    cmd.op = OP_MUL_SQ;
         S_R:         cmd.op = sts.q_zero ? OP_R_ZERO : OP_R_DIV;
         S_INV_INIT: begin
            if (!sts.q_lt2) begin
               cmd.op = OP_K_RED;
            end
         end
         S_EU_LOOP: begin
            if (!sts.r1_zero) begin
               cmd.op = OP_EU_DIV;
            end
         end
         S_EU_MUL:    cmd.op = OP_EU_MUL;
         S_EU_STEP:   cmd.op = OP_EU_STEP;
         S_H_RED:     cmd.op = OP_H_RED;
         S_XR:        cmd.op = OP_XR_MUL;
         S_T_ADD:     cmd.op = OP_T_ADD;
         S_S_MUL:     cmd.op = OP_S_MUL;
         S_FAIL:      cmd.op = OP_S_ZERO;
         S_OUT: begin
            if (sts.out_free) begin
               cmd.op = OP_OUT;
            end
         end
         default: cmd.op = OP_NONE;
      endcase
   end

endmodule

>>> rtl/dsa_signature_sign.sv
`timescale 1ns / 1ps
// one item at a time; latency is data dependent: three exponentiations and the inverse all
// run on one bit-serial modular multiplier and one restoring divider
// a finished result waits in the output register while the next item is accepted
// synchronous active-high reset restores the configuration defaults and empties the output
`include "dsa_signature_sign_macros.svh"
module dsa_signature_sign import dss_pkg::*; #(
   parameter int MOD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   dss_req_if.sink     req_ch,
   dss_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type cfg_ff;
   cmd_type dp_cmd;
   sts_type dp_sts;

   logic [MOD_BITS-1:0] sig_r_w, sig_s_w, public_key_w;
   logic                rsp_noninv, rsp_ok, req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.modulus_p      <= RST_MODULUS_P;
         cfg_ff.subgroup_q     <= RST_SUBGROUP_Q;
         cfg_ff.generator_seed <= RST_GENERATOR_SEED;
         cfg_ff.private_key    <= RST_PRIVATE_KEY;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODULUS_P:      cfg_ff.modulus_p      <= csr_wdata;
            CSR_SUBGROUP_Q:     cfg_ff.subgroup_q     <= csr_wdata;
            CSR_GENERATOR_SEED: cfg_ff.generator_seed <= csr_wdata;
            CSR_PRIVATE_KEY:    cfg_ff.private_key    <= csr_wdata;
            default: ;
         endcase
      end
   end

   dss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (dp_cmd),
      .sts       (dp_sts)
   );

   dss_datapath #(.MOD_BITS(MOD_BITS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dp_cmd),
      .sts        (dp_sts),
      .cfg        (cfg_ff),
      .message    (req_ch.message),
      .hash_key   (req_ch.hash_key),
      .nonce      (req_ch.nonce),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .sig_r      (sig_r_w),
      .sig_s      (sig_s_w),
      .public_key (public_key_w),
      .status     (rsp_ch.status)
   );

   assign rsp_ch.sig_r      = 16'(sig_r_w);
   assign rsp_ch.sig_s      = 16'(sig_s_w);
   assign rsp_ch.public_key = 16'(public_key_w);

   assign rsp_noninv = rsp_ch.valid && (rsp_ch.status == ST_NONINV);
   assign rsp_ok     = rsp_ch.valid && (rsp_ch.status == ST_OK);
   assign req_take   = req_ch.valid && req_ch.ready;

   `DSS_ASSERT_IMP(a_noninv_s_zero, rsp_noninv, rsp_ch.sig_s == 16'd0, "nonzero s on bad nonce")
   `DSS_ASSERT_IMP(a_ok_nonzero, rsp_ok, (rsp_ch.sig_r != '0) && (rsp_ch.sig_s != '0), "ok, part 0")
   `DSS_ASSERT_IMP(a_busy_no_accept, dp_sts.busy, !req_ch.ready, "ready while unit busy")
   `DSS_ASSERT_NXT(a_load_starts_work, req_take, !req_ch.ready, "ready held after an item")

endmodule
